FILE: rtl/ppg_agc_pkg.sv
// Shared types and constants for the PPG LED and gain AGC block.
// Used by the channel interfaces, the top level and the checker.
// No dependencies.
package ppg_agc_pkg;

    localparam int SampleW = 22;
    localparam int LevelW  = 21;
    localparam int LedW    = 6;
    localparam int GainW   = 2;
    localparam int PeriodW = 4;
    localparam int AddrW   = 3;
    localparam int DataW   = 21;

    // Register indexes on the configuration channel
    localparam logic [AddrW-1:0] RegSatLevel   = 3'd0;
    localparam logic [AddrW-1:0] RegWeakLevel  = 3'd1;
    localparam logic [AddrW-1:0] RegRaiseLevel = 3'd2;
    localparam logic [AddrW-1:0] RegLedCeiling = 3'd3;
    localparam logic [AddrW-1:0] RegLedFloor   = 3'd4;
    localparam logic [AddrW-1:0] RegPeriod     = 3'd5;

    // Register reset values
    localparam logic [LevelW-1:0]  SatLevelRst   = 21'd1992294;
    localparam logic [LevelW-1:0]  WeakLevelRst  = 21'd1000000;
    localparam logic [LevelW-1:0]  RaiseLevelRst = 21'd350000;
    localparam logic [LedW-1:0]    LedCeilingRst = 6'd25;
    localparam logic [LedW-1:0]    LedFloorRst   = 6'd10;
    localparam logic [PeriodW-1:0] PeriodRst     = 4'd4;

    // Gain index codes
    localparam logic [GainW-1:0] GainLow     = 2'd0;
    localparam logic [GainW-1:0] GainDefault = 2'd1;
    localparam logic [GainW-1:0] GainCodeTop = 2'd3;

    localparam logic [PeriodW-1:0] WeakCountMax = 4'd15;

endpackage

FILE: rtl/ppg_agc_if.sv
// Valid/ready channel interfaces for the PPG LED and gain AGC block.
// Depends on ppg_agc_pkg for field widths.

interface ppg_agc_sample_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [ppg_agc_pkg::SampleW-1:0]    ppg_sample;
    logic                                      worn;

    modport source (output valid, output ppg_sample, output worn, input ready);
    modport sink   (input valid, input ppg_sample, input worn, output ready);
endinterface

interface ppg_agc_result_if;
    logic                               valid;
    logic                               ready;
    logic [ppg_agc_pkg::LedW-1:0]       led_level;
    logic [ppg_agc_pkg::GainW-1:0]      gain_index;
    logic [ppg_agc_pkg::GainW-1:0]      gain_code;

    modport source (output valid, output led_level, output gain_index, output gain_code,
                    input ready);
    modport sink   (input valid, input led_level, input gain_index, input gain_code,
                    output ready);
endinterface

interface ppg_agc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ppg_agc_pkg::AddrW-1:0]      addr;
    logic [ppg_agc_pkg::DataW-1:0]      data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/ppg_led_gain_agc_top.sv
// Top level of the PPG LED drive and amplifier gain AGC.
// Depends on ppg_agc_pkg and the channel interfaces in ppg_agc_if.sv.
//
// Channel  | Dir | Payload                                   | Beat taken when
// ---------+-----+-------------------------------------------+-------------------
// sample   | in  | ppg_sample (s22), worn (1)                | valid && ready
// result   | out | led_level (6), gain_index (2), gain_code  | valid && ready
// cfg      | in  | addr (3), data (21)                       | valid && ready
//
// One sample beat per cycle sustained while the result channel is not stalled;
// each sample yields one result beat via the input register, then the result register.
// The loop that sets the rate is the AGC state update: led, gain, weak count
// and armed flag are read and rewritten in the same cycle that moves a
// sample from the input register into the result register.
// rst_n clears the AGC state and loads register defaults; cfg is always ready.
// A stalled result holds the result register, then the input register; the
// sample channel is ready whenever the input register is empty or will move.
module ppg_led_gain_agc_top (
    input  logic               clk,
    input  logic               rst_n,
    ppg_agc_sample_if.sink     sample,
    ppg_agc_result_if.source   result,
    ppg_agc_cfg_if.sink        cfg
);
    import ppg_agc_pkg::*;

    // Configuration registers
    logic [LevelW-1:0]  sat_level_reg;
    logic [LevelW-1:0]  weak_level_reg;
    logic [LevelW-1:0]  raise_level_reg;
    logic [LedW-1:0]    led_ceiling_reg;
    logic [LedW-1:0]    led_floor_reg;
    logic [PeriodW-1:0] period_reg;

    // AGC state
    logic [LedW-1:0]    led_level_reg,  led_level_next;
    logic [GainW-1:0]   gain_index_reg, gain_index_next;
    logic [PeriodW-1:0] weak_count_reg, weak_count_next;
    logic               armed_reg,      armed_next;

    // Input register
    logic                      in_valid_reg;
    logic signed [SampleW-1:0] in_sample_reg;
    logic                      in_worn_reg;

    // Result register
    logic                out_valid_reg;
    logic [LedW-1:0]     out_led_reg;
    logic [GainW-1:0]    out_gain_reg;

    logic               advance;
    logic               take_in;
    logic [SampleW-1:0] magnitude;
    logic               neg;
    logic               is_sat;
    logic               is_weak;
    logic               is_small;
    logic [PeriodW-1:0] count_inc;
    logic               period_due;

    // The input register moves on when the result register is empty or drains.
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || !out_valid_reg || result.ready;
    assign take_in      = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.led_level  = out_led_reg;
    assign result.gain_index = out_gain_reg;
    assign result.gain_code  = GainCodeTop - out_gain_reg;

    // Work in magnitude: for negative samples, s <= -sat is |s| >= sat and
    // s > -weak is |s| < weak, so both signs share one set of compares.
    // The most negative sample gives 2^21, which still fits the 22-bit word.
    assign neg       = in_sample_reg[SampleW-1];
    assign magnitude = neg ? (~in_sample_reg + 1'b1) : in_sample_reg;
    assign is_sat    = magnitude >= {1'b0, sat_level_reg};
    assign is_weak   = magnitude <  {1'b0, weak_level_reg};
    assign is_small  = magnitude <  {1'b0, raise_level_reg};

    // Weak counter saturates, then clears when it reaches the period.
    assign count_inc  = (weak_count_reg < WeakCountMax) ? (weak_count_reg + 1'b1)
                                                         : WeakCountMax;
    assign period_due = count_inc >= period_reg;

    always_comb
    begin
        led_level_next  = led_level_reg;
        gain_index_next = gain_index_reg;
        weak_count_next = weak_count_reg;
        armed_next      = armed_reg;
        if (!in_worn_reg)
        begin
            // Off the wrist: LED off, rearm on next attach
            led_level_next = '0;
            armed_next     = 1'b0;
        end
        else if (!armed_reg)
        begin
            // First worn sample: full LED, default gain
            led_level_next  = led_ceiling_reg;
            gain_index_next = GainDefault;
            armed_next      = 1'b1;
        end
        else if (is_sat)
        begin
            // Saturation wins over weakness; drop gain first
            if (gain_index_reg != GainLow)
                gain_index_next = gain_index_reg - 1'b1;
            else if (!neg && led_level_reg > led_floor_reg)
                led_level_next = led_level_reg - 1'b1;
            else if (neg && led_level_reg < led_ceiling_reg)
                led_level_next = led_level_reg + 1'b1;
        end
        else if (is_weak)
        begin
            weak_count_next = period_due ? '0 : count_inc;
            if (period_due)
            begin
                if (gain_index_reg == GainLow && is_small)
                    gain_index_next = GainDefault;
                else if (!neg && led_level_reg < led_ceiling_reg)
                    led_level_next = led_level_reg + 1'b1;
            end
        end
    end

    // Configuration writes; addresses past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_level_reg   <= SatLevelRst;
            weak_level_reg  <= WeakLevelRst;
            raise_level_reg <= RaiseLevelRst;
            led_ceiling_reg <= LedCeilingRst;
            led_floor_reg   <= LedFloorRst;
            period_reg      <= PeriodRst;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                RegSatLevel:   sat_level_reg   <= cfg.data;
                RegWeakLevel:  weak_level_reg  <= cfg.data;
                RegRaiseLevel: raise_level_reg <= cfg.data;
                RegLedCeiling: led_ceiling_reg <= cfg.data[LedW-1:0];
                RegLedFloor:   led_floor_reg   <= cfg.data[LedW-1:0];
                RegPeriod:     period_reg      <= cfg.data[PeriodW-1:0];
                default:       ;
            endcase
        end
    end

    // Control: valids and AGC state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            led_level_reg  <= '0;
            gain_index_reg <= '0;
            weak_count_reg <= '0;
            armed_reg      <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                led_level_reg  <= led_level_next;
                gain_index_reg <= gain_index_next;
                weak_count_reg <= weak_count_next;
                armed_reg      <= armed_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_sample_reg <= sample.ppg_sample;
            in_worn_reg   <= sample.worn;
        end
        if (advance)
        begin
            out_led_reg  <= led_level_next;
            out_gain_reg <= gain_index_next;
        end
    end

endmodule

FILE: rtl/ppg_agc_chk.sv
// Port-level checker for the PPG LED and gain AGC, bound to the top level.
// Depends on ppg_agc_pkg and ppg_led_gain_agc_top.
module ppg_agc_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [ppg_agc_pkg::LedW-1:0]  led_level,
    input logic [ppg_agc_pkg::GainW-1:0] gain_index,
    input logic [ppg_agc_pkg::GainW-1:0] gain_code
);
    import ppg_agc_pkg::*;

    // Gain code always mirrors the index
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (gain_code == GainCodeTop - gain_index))
    else $error("gain_code does not match gain_index");

    // The index never reaches the top gain code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (gain_index != GainCodeTop))
    else $error("gain_index out of range");

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(led_level) && $stable(gain_index)))
    else $error("stalled result beat changed");

endmodule

bind ppg_led_gain_agc_top ppg_agc_chk u_ppg_agc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .led_level    (result.led_level),
    .gain_index   (result.gain_index),
    .gain_code    (result.gain_code)
);
